/* sv/bpqd_pkg.sv */
package bpqd_pkg;

    localparam int KEY_W    = 16;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 3;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVICTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
    } cmd_t;

endpackage

/* sv/bpqd_cell.sv */
module bpqd_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  bpqd_pkg::cmd_t cmd,
    input  bpqd_pkg::slot_t left_slot,
    input  logic           left_go,
    input  bpqd_pkg::slot_t right_slot,
    input  logic           seen_in,
    output bpqd_pkg::slot_t slot,
    output logic           go,
    output logic           seen_out
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [bpqd_pkg::KEY_W-1:0]  key_reg;
    logic [bpqd_pkg::KEY_W-1:0]  key_next;
    logic [bpqd_pkg::PRIO_W-1:0] prio_reg;
    logic [bpqd_pkg::PRIO_W-1:0] prio_next;
    logic                        match;

    assign slot.valid = valid_reg;
    assign slot.key   = key_reg;
    assign slot.prio  = prio_reg;

    // go: the new item belongs behind this cell
    assign go       = valid_reg && (prio_reg >= cmd.prio);
    assign match    = valid_reg && (key_reg == cmd.key);
    assign seen_out = seen_in || match;

    always_comb
    begin
        priority if (cmd.ins && !go)
        begin
            if (left_go)
            begin
                // insert point: take the new item
                valid_next = 1'b1;
                key_next   = cmd.key;
                prio_next  = cmd.prio;
            end
            else
            begin
                // behind the insert point: shift toward the tail
                valid_next = left_slot.valid;
                key_next   = left_slot.key;
                prio_next  = left_slot.prio;
            end
        end
        else if (cmd.rem && seen_out)
        begin
            // at or behind the removed cell: close the gap
            valid_next = right_slot.valid;
            key_next   = right_slot.key;
            prio_next  = right_slot.prio;
        end
        else
        begin
            // hold
            valid_next = valid_reg;
            key_next   = key_reg;
            prio_next  = prio_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
    end

endmodule

/* sv/bounded_priority_queue_dedup.sv */
// Bounded priority queue with duplicate rejection. The queue is a row of
// QUEUE_DEPTH cells, packed from cell 0 (the head) and ordered by priority,
// higher first, older first among equals. Each cell compares its own entry
// with the incoming key and priority; an insert shifts the cells behind the
// insert point one step toward the tail, a remove shifts the cells from the
// matching one onward one step toward the head. An insert of a key already
// queued returns "duplicate"; an insert into a full queue evicts the tail
// when the new priority is strictly higher, else returns "full". Every item
// yields exactly one result carrying status, evicted key, count and head.
// Rate: one item per unstalled clock. The whole row settles in the cycle the
// item is accepted; the longest path is the key-match chain that runs
// through all cells for a remove. The result comes next cycle: status,
// evicted key and count sit in an output register, and the head fields come
// straight from cell 0, which holds still while a result waits. req_stall
// rises only while the output register holds a result that rsp_stall keeps.
// No clearing pass after reset: the valid bits of the cells clear at once.
module bounded_priority_queue_dedup #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          func,
    input  logic [bpqd_pkg::KEY_W-1:0]    entry_key,
    input  logic [bpqd_pkg::PRIO_W-1:0]   entry_priority,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [bpqd_pkg::STATUS_W-1:0] status,
    output logic [bpqd_pkg::KEY_W-1:0]    evicted_key,
    output logic [3:0]                    queue_count,
    output logic                          head_valid,
    output logic [bpqd_pkg::KEY_W-1:0]    head_key
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_XW = (CNT_W > 4) ? CNT_W : 4;

    bpqd_pkg::cmd_t  cmd;
    bpqd_pkg::slot_t slot [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] go;
    logic [QUEUE_DEPTH:0]   seen;
    logic [QUEUE_DEPTH-1:0] valid_vec;

    logic accept;
    logic hit;
    logic full;
    logic tail_go;
    logic ins_ok;

    logic [bpqd_pkg::STATUS_W-1:0] status_calc;
    logic [bpqd_pkg::KEY_W-1:0]    evicted_calc;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_XW-1:0] count_ext;

    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic [bpqd_pkg::STATUS_W-1:0] status_reg;
    logic [bpqd_pkg::KEY_W-1:0]    evicted_reg;
    logic [3:0]                    count_out_reg;

    // hold the input while the output register keeps an untaken result
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // seen chain ends in "key is queued somewhere"
    assign seen[0] = 1'b0;
    assign hit     = seen[QUEUE_DEPTH];
    assign full    = slot[QUEUE_DEPTH-1].valid;
    // tail still outranks or ties the new item: nowhere to put it
    assign tail_go = go[QUEUE_DEPTH-1];
    assign ins_ok  = !hit && !tail_go;

    assign cmd.ins  = accept && (func == bpqd_pkg::FUNC_INSERT) && ins_ok;
    assign cmd.rem  = accept && (func == bpqd_pkg::FUNC_REMOVE) && hit;
    assign cmd.key  = entry_key;
    assign cmd.prio = entry_priority;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            bpqd_pkg::slot_t left_slot;
            bpqd_pkg::slot_t right_slot;
            logic            left_go;

            if (i == 0)
            begin : g_head
                assign left_slot = '0;
                assign left_go   = 1'b1;
            end
            else
            begin : g_body
                assign left_slot = slot[i-1];
                assign left_go   = go[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_slot = '0;
            end
            else
            begin : g_mid
                assign right_slot = slot[i+1];
            end

            bpqd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_slot  (left_slot),
                .left_go    (left_go),
                .right_slot (right_slot),
                .seen_in    (seen[i]),
                .slot       (slot[i]),
                .go         (go[i]),
                .seen_out   (seen[i+1])
            );

            assign valid_vec[i] = slot[i].valid;
        end
    endgenerate

    always_comb
    begin
        evicted_calc = '0;
        if (func == bpqd_pkg::FUNC_INSERT)
        begin
            priority if (hit)
            begin
                status_calc = bpqd_pkg::ST_DUPLICATE;
            end
            else if (tail_go)
            begin
                status_calc = bpqd_pkg::ST_FULL;
            end
            else if (full)
            begin
                status_calc  = bpqd_pkg::ST_EVICTED;
                evicted_calc = slot[QUEUE_DEPTH-1].key;
            end
            else
            begin
                status_calc = bpqd_pkg::ST_INSERTED;
            end
        end
        else
        begin
            status_calc = hit ? bpqd_pkg::ST_REMOVED : bpqd_pkg::ST_NOT_FOUND;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_ext = CNT_XW'(count_next);

    // drop the result once taken unless a new item replaces it
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_calc;
            evicted_reg   <= evicted_calc;
            count_out_reg <= count_ext[3:0];
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign evicted_key = evicted_reg;
    assign queue_count = count_out_reg;
    // cell 0 only moves on an accepted item, so it matches the waiting result
    assign head_valid  = slot[0].valid;
    assign head_key    = slot[0].valid ? slot[0].key : '0;

`ifndef SYNTH
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("count disagrees with cell valid bits");

    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)
        else $error("valid cells not packed at the head");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted item produced no result");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == bpqd_pkg::ST_EVICTED) |->
        (int'(count_reg) == QUEUE_DEPTH))
        else $error("eviction reported while queue not full");
`endif

endmodule
